// ----- rtl/core/lpfr_pkg.sv -----
// lpfr_pkg: types and constants shared by the length-prefixed frame receiver
// no dependencies; used by lpfr_deframer, the top level and the testbench
`default_nettype none

package lpfr_pkg;

   // item codes on the request channel
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // result kinds
   localparam logic KIND_PAYLOAD   = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   // frame layout and counter limits
   localparam int unsigned POS_W          = 17;
   localparam int unsigned IDLE_W         = 9;
   localparam logic [POS_W-1:0]  HEADER_BYTES   = 17'd4;
   localparam logic [POS_W-1:0]  CMD_BYTES      = 17'd2;
   localparam logic [POS_W-1:0]  FRAME_OVERHEAD = 17'd5;
   localparam logic [IDLE_W-1:0] IDLE_SAT       = 9'd256;
   localparam logic [7:0]        TIMEOUT_RESET  = 8'd5;

   // one result item
   typedef struct packed {
      logic        result_kind;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
      logic [15:0] frame_command;
      logic [15:0] frame_length;
      logic        frame_good;
   } result_type;

   // deframer outcome for the item currently presented
   typedef struct packed {
      logic       has_result;
      result_type result;
   } step_out_type;

endpackage

`default_nettype wire

// ----- rtl/core/lpfr_req_if.sv -----
// lpfr_req_if: request channel carrying received bytes and millisecond ticks
// depends on nothing
`default_nettype none

interface lpfr_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lpfr_rsp_if.sv -----
// lpfr_rsp_if: result channel carrying payload bytes and frame-end items
// depends on nothing
`default_nettype none

interface lpfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  payload_byte;
   logic [15:0] payload_index;
   logic [15:0] frame_command;
   logic [15:0] frame_length;
   logic        frame_good;

   modport source (output valid, output result_kind, output payload_byte,
                   output payload_index, output frame_command, output frame_length,
                   output frame_good, input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input payload_index, input frame_command, input frame_length,
                   input frame_good, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lpfr_csr_if.sv -----
// lpfr_csr_if: write channel for the idle timeout register
// depends on nothing
`default_nettype none

interface lpfr_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lpfr_deframer.sv -----
// lpfr_deframer: frame state (position, sum, header words, idle counter)
// and the per-item update; depends on lpfr_pkg
`default_nettype none

module lpfr_deframer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic                cmd,
   input  wire logic [7:0]          rx_byte,
   input  wire logic [7:0]          idle_timeout_ms,
   output lpfr_pkg::step_out_type   step_out
);

   logic [lpfr_pkg::POS_W-1:0]  byte_position_ff, byte_position_in;
   logic [7:0]                  running_sum_ff, running_sum_in;
   logic [15:0]                 command_word_ff, command_word_in;
   logic [15:0]                 length_word_ff, length_word_in;
   logic [lpfr_pkg::POS_W-1:0]  frame_total_ff, frame_total_in;
   logic [lpfr_pkg::IDLE_W-1:0] idle_ms_ff, idle_ms_in;

   logic                        start_over;
   logic [lpfr_pkg::POS_W-1:0]  pos;
   logic [lpfr_pkg::POS_W:0]    pos_inc;
   logic [7:0]                  sum_new;
   logic                        in_cmd_bytes;
   logic                        in_len_bytes;
   logic                        is_payload;
   logic                        is_end;
   logic [lpfr_pkg::POS_W-1:0]  payload_offset;

   // byte path: restart on idle timeout, fold byte into header and sum
   always_comb begin
      start_over     = idle_ms_ff > {1'b0, idle_timeout_ms};
      pos            = start_over ? '0 : byte_position_ff;
      sum_new        = (start_over ? 8'd0 : running_sum_ff) + rx_byte;
      in_cmd_bytes   = pos < lpfr_pkg::CMD_BYTES;
      in_len_bytes   = !in_cmd_bytes && (pos < lpfr_pkg::HEADER_BYTES);
      pos_inc        = {1'b0, pos} + 18'd1;
      payload_offset = pos - lpfr_pkg::HEADER_BYTES;

      command_word_in = in_cmd_bytes ? {command_word_ff[7:0], rx_byte} : command_word_ff;
      length_word_in  = in_len_bytes ? {length_word_ff[7:0], rx_byte} : length_word_ff;
      frame_total_in  = in_len_bytes ? ({1'b0, length_word_in} + lpfr_pkg::FRAME_OVERHEAD)
                                     : frame_total_ff;

      is_payload = !in_cmd_bytes && !in_len_bytes && (pos_inc < {1'b0, frame_total_ff});
      is_end     = pos_inc[lpfr_pkg::POS_W-1:0] == frame_total_in;

      byte_position_in = is_end ? '0 : pos_inc[lpfr_pkg::POS_W-1:0];
      running_sum_in   = is_end ? 8'd0 : sum_new;

      // idle counter saturates
      if (cmd == lpfr_pkg::CMD_TICK) begin
         idle_ms_in = (idle_ms_ff < lpfr_pkg::IDLE_SAT) ? idle_ms_ff + 9'd1 : idle_ms_ff;
      end else begin
         idle_ms_in = '0;
      end
   end

   // result for the presented item
   always_comb begin
      step_out = '0;
      if (cmd == lpfr_pkg::CMD_BYTE) begin
         if (is_end) begin
            step_out.has_result           = 1'b1;
            step_out.result.result_kind   = lpfr_pkg::KIND_FRAME_END;
            step_out.result.frame_command = command_word_in;
            step_out.result.frame_length  = length_word_in;
            step_out.result.frame_good    = sum_new == 8'd0;
         end else if (is_payload) begin
            step_out.has_result           = 1'b1;
            step_out.result.result_kind   = lpfr_pkg::KIND_PAYLOAD;
            step_out.result.payload_byte  = rx_byte;
            step_out.result.payload_index = payload_offset[15:0];
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         running_sum_ff   <= '0;
         command_word_ff  <= '0;
         length_word_ff   <= '0;
         frame_total_ff   <= '0;
         idle_ms_ff       <= '0;
      end else if (step) begin
         idle_ms_ff <= idle_ms_in;
         if (cmd == lpfr_pkg::CMD_BYTE) begin
            byte_position_ff <= byte_position_in;
            running_sum_ff   <= running_sum_in;
            command_word_ff  <= command_word_in;
            length_word_ff   <= length_word_in;
            frame_total_ff   <= frame_total_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/length_prefixed_frame_receiver_unit.sv -----
// length_prefixed_frame_receiver_unit: input register, deframer, result register
// an accepted item sits in the input register; when it advances, its result is registered
// throughput: one item per cycle while results are taken; the result register
// stalls only items that produce a result. csr write ready is always high
// reset: synchronous, clears frame state, idle counter; timeout register to 5
// depends on lpfr_pkg, lpfr_req_if, lpfr_rsp_if, lpfr_csr_if, lpfr_deframer
`default_nettype none

module length_prefixed_frame_receiver_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   lpfr_req_if.sink   req_chan,
   lpfr_rsp_if.source rsp_chan,
   lpfr_csr_if.sink   csr_chan
);

   logic                  in_valid_ff;
   logic                  in_cmd_ff;
   logic [7:0]            in_byte_ff;
   logic [7:0]            timeout_ff;
   logic                  rsp_valid_ff;
   lpfr_pkg::result_type  rsp_data_ff;
   lpfr_pkg::step_out_type step_out;
   logic                  advance;

   // deframer works on the registered item
   lpfr_deframer u_deframer (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .cmd             (in_cmd_ff),
      .rx_byte         (in_byte_ff),
      .idle_timeout_ms (timeout_ff),
      .step_out        (step_out)
   );

   // item moves on unless its result has no room
   assign advance = in_valid_ff &&
                    (!step_out.has_result || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   // timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= lpfr_pkg::TIMEOUT_RESET;
      end else if (csr_chan.valid) begin
         timeout_ff <= csr_chan.data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_cmd_ff  <= req_chan.cmd;
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && step_out.has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_out.has_result) begin
         rsp_data_ff <= step_out.result;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.result_kind   = rsp_data_ff.result_kind;
   assign rsp_chan.payload_byte  = rsp_data_ff.payload_byte;
   assign rsp_chan.payload_index = rsp_data_ff.payload_index;
   assign rsp_chan.frame_command = rsp_data_ff.frame_command;
   assign rsp_chan.frame_length  = rsp_data_ff.frame_length;
   assign rsp_chan.frame_good    = rsp_data_ff.frame_good;

endmodule

`default_nettype wire

// ----- sim/length_prefixed_frame_receiver_unit_tb.sv -----
// testbench for length_prefixed_frame_receiver_unit: streams frames, ticks and noise,
// predicts payload and frame-end items and checks them in order
// depends on lpfr_pkg, the lpfr_req_if, lpfr_rsp_if and lpfr_csr_if interfaces and the rtl
`timescale 1ns / 1ps

module length_prefixed_frame_receiver_unit_tb;

   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 4;
   localparam int IDLE_PERCENT = 8;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } rx_item_type;

   logic clock;
   logic reset;

   lpfr_req_if req_bus ();
   lpfr_rsp_if rsp_bus ();
   lpfr_csr_if csr_bus ();

   length_prefixed_frame_receiver_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // stimulus and expected items
   rx_item_type          rx_stream_q[$];
   lpfr_pkg::result_type deframed_q[$];
   int                   items_queued = 0;
   int                   error_count  = 0;
   int                   quiet_cycles = 0;
   logic                 calm         = 1'b0;
   logic                 req_taken    = 1'b0;

   // deframer state as seen by the predictor
   logic [7:0]                  timeout_q = lpfr_pkg::TIMEOUT_RESET;
   logic [lpfr_pkg::POS_W-1:0]  frame_pos = '0;
   logic [7:0]                  sum_acc   = '0;
   logic [15:0]                 cmd_word  = '0;
   logic [15:0]                 len_word  = '0;
   logic [lpfr_pkg::POS_W-1:0]  frame_end = '0;
   logic [lpfr_pkg::IDLE_W-1:0] idle_cnt  = '0;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // predictor: one byte or tick in, at most one expected item out
   task automatic deframe_step(input rx_item_type item);
      lpfr_pkg::result_type       res;
      logic [lpfr_pkg::POS_W-1:0] pos;
      logic [lpfr_pkg::POS_W-1:0] offset;
      logic                       emit;
      emit = 1'b0;
      res  = '0;
      if (item.cmd == lpfr_pkg::CMD_TICK) begin
         if (idle_cnt < lpfr_pkg::IDLE_SAT) idle_cnt = idle_cnt + 9'd1;
      end else begin
         // a byte after too long a silence starts a new frame
         if (idle_cnt > {1'b0, timeout_q}) begin
            frame_pos = '0;
            sum_acc   = '0;
         end
         idle_cnt = '0;
         sum_acc  = sum_acc + item.rx_byte;
         pos      = frame_pos;
         if (pos < lpfr_pkg::CMD_BYTES) begin
            cmd_word = {cmd_word[7:0], item.rx_byte};
         end else if (pos < lpfr_pkg::HEADER_BYTES) begin
            len_word  = {len_word[7:0], item.rx_byte};
            frame_end = {1'b0, len_word} + lpfr_pkg::FRAME_OVERHEAD;
         end else if (pos + 17'd1 < frame_end) begin
            offset            = pos - lpfr_pkg::HEADER_BYTES;
            res.result_kind   = lpfr_pkg::KIND_PAYLOAD;
            res.payload_byte  = item.rx_byte;
            res.payload_index = offset[15:0];
            emit              = 1'b1;
         end
         frame_pos = pos + 17'd1;
         // checksum byte closes the frame
         if (frame_pos == frame_end) begin
            res               = '0;
            res.result_kind   = lpfr_pkg::KIND_FRAME_END;
            res.frame_command = cmd_word;
            res.frame_length  = len_word;
            res.frame_good    = (sum_acc == 8'd0);
            emit              = 1'b1;
            frame_pos         = '0;
            sum_acc           = '0;
         end
         if (emit) deframed_q.push_back(res);
      end
   endtask

   function automatic void check_field(input string name, input logic [15:0] exp_val,
                                       input logic [15:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
         error_count++;
      end
   endfunction

   // handshakes: check results, feed the predictor, track the register, watchdog
   always @(posedge clock) begin : track_items
      lpfr_pkg::result_type exp_res;
      logic                 moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            if (deframed_q.size() == 0) begin
               $error("result item with none expected, kind %0d", rsp_bus.result_kind);
               error_count++;
            end else begin
               exp_res = deframed_q.pop_front();
               check_field("result_kind", 16'(exp_res.result_kind),
                           16'(rsp_bus.result_kind));
               check_field("payload_byte", 16'(exp_res.payload_byte),
                           16'(rsp_bus.payload_byte));
               check_field("payload_index", exp_res.payload_index, rsp_bus.payload_index);
               check_field("frame_command", exp_res.frame_command, rsp_bus.frame_command);
               check_field("frame_length", exp_res.frame_length, rsp_bus.frame_length);
               check_field("frame_good", 16'(exp_res.frame_good), 16'(rsp_bus.frame_good));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            moved = 1'b1;
            deframe_step('{cmd: req_bus.cmd, rx_byte: req_bus.rx_byte});
         end
         if (csr_bus.valid && csr_bus.ready) begin
            moved     = 1'b1;
            timeout_q = csr_bus.data;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("length_prefixed_frame_receiver_unit test failed");
            $finish;
         end
      end
      req_taken <= req_bus.valid && req_bus.ready;
   end

   // request driver: next item from the stream, with random gaps
   always @(negedge clock) begin : drive_rx
      rx_item_type next_item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (rx_stream_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            next_item = rx_stream_q.pop_front();
            req_bus.valid   <= 1'b1;
            req_bus.cmd     <= next_item.cmd;
            req_bus.rx_byte <= next_item.rx_byte;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin : drive_rsp_ready
      rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // stream builders
   task automatic push_tick(input int count);
      rx_item_type item;
      for (int i = 0; i < count; i++) begin
         item.cmd     = lpfr_pkg::CMD_TICK;
         item.rx_byte = 8'($urandom_range(0, 255));
         rx_stream_q.push_back(item);
         items_queued++;
      end
   endtask

   task automatic push_byte(input logic [7:0] value, input int gap_max);
      rx_item_type item;
      if (gap_max > 0 && $urandom_range(0, 3) == 0) push_tick(int'($urandom_range(0, gap_max)));
      item.cmd     = lpfr_pkg::CMD_BYTE;
      item.rx_byte = value;
      rx_stream_q.push_back(item);
      items_queued++;
   endtask

   task automatic add_frame(input logic [15:0] command, input logic [15:0] length,
                            input logic bad_sum, input int gap_max);
      logic [7:0] sum;
      logic [7:0] value;
      sum = command[15:8] + command[7:0] + length[15:8] + length[7:0];
      push_byte(command[15:8], gap_max);
      push_byte(command[7:0], gap_max);
      push_byte(length[15:8], gap_max);
      push_byte(length[7:0], gap_max);
      for (int i = 0; i < length; i++) begin
         value = 8'($urandom_range(0, 255));
         sum   = sum + value;
         push_byte(value, gap_max);
      end
      value = 8'd0 - sum;
      if (bad_sum) value = value + 8'($urandom_range(1, 255));
      push_byte(value, gap_max);
   endtask

   // mostly whole frames, some cut short or noisy, some tick bursts
   task automatic run_random(input int item_budget);
      int          stop_at;
      int          gap_max;
      int          pick;
      logic [31:0] word;
      stop_at = items_queued + item_budget;
      gap_max = (timeout_q > 6) ? 6 : int'(timeout_q);
      while (items_queued < stop_at) begin
         pick = int'($urandom_range(0, 99));
         if (pick < 70) begin
            add_frame(16'($urandom), 16'($urandom_range(0, 12)), $urandom_range(0, 4) == 0,
                      $urandom_range(0, 1) ? gap_max : 0);
         end else if (pick < 80) begin
            // header with any length, a few bytes, then silence
            word = $urandom;
            for (int i = 0; i < 4; i++) push_byte(word[8*i +: 8], 0);
            for (int i = int'($urandom_range(0, 3)); i > 0; i--)
               push_byte(8'($urandom_range(0, 255)), 0);
            push_tick(int'(timeout_q) + 1);
         end else if (pick < 90) begin
            for (int i = int'($urandom_range(1, 6)); i > 0; i--)
               push_byte(8'($urandom_range(0, 255)), 0);
            push_tick(int'(timeout_q) + 1);
         end else begin
            push_tick(int'($urandom_range(1, 8)));
         end
      end
   endtask

   task automatic wait_idle();
      while (rx_stream_q.size() != 0 || req_bus.valid || deframed_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [7:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // sequence of phases
   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.cmd     = lpfr_pkg::CMD_BYTE;
      req_bus.rx_byte = 8'd0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.data    = 8'd0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero length, bad checksum, silence at and just past the timeout
      add_frame(16'hFFFF, 16'd0, 1'b0, 0);
      add_frame(16'h0000, 16'd1, 1'b1, 0);
      push_byte(8'h12, 0);
      push_byte(8'h34, 0);
      push_tick(int'(lpfr_pkg::TIMEOUT_RESET));
      push_byte(8'h00, 0);
      push_byte(8'h01, 0);
      push_tick(int'(lpfr_pkg::TIMEOUT_RESET) + 1);
      wait_idle();

      // shortest timeout: any tick restarts
      write_timeout(8'd0);
      run_random(60);
      wait_idle();

      // longest timeout: partial header, a silence that saturates the idle counter
      write_timeout(8'd255);
      push_byte(8'h5A, 0);
      push_byte(8'hC3, 0);
      push_tick(257);
      add_frame(16'h0102, 16'd3, 1'b0, 6);
      add_frame(16'h8001, 16'd2, 1'b1, 6);
      wait_idle();

      // random timeout, no idling on either side
      write_timeout(8'($urandom_range(1, 20)));
      calm = 1'b1;
      run_random(60);
      wait_idle();
      calm = 1'b0;

      // back to the reset timeout, a header with the largest length then silence
      write_timeout(lpfr_pkg::TIMEOUT_RESET);
      push_byte(8'hA5, 0);
      push_byte(8'h5A, 0);
      push_byte(8'hFF, 0);
      push_byte(8'hFF, 0);
      for (int i = 0; i < 3; i++) push_byte(8'($urandom_range(0, 255)), 0);
      push_tick(int'(lpfr_pkg::TIMEOUT_RESET) + 1);
      run_random(20);
      wait_idle();

      if (error_count == 0) begin
         $display("length_prefixed_frame_receiver_unit test passed");
      end else begin
         $display("length_prefixed_frame_receiver_unit test failed");
      end
      $finish;
   end

endmodule
